/* hw/rtl/llcb_pkg.sv */
// Shared types, defaults and command codes of the least loaded CPU bucket list.
`default_nettype none

package llcb_pkg;

  // Default sizes
  localparam int NumCpusDef   = 16;
  localparam int NumLevelsDef = 16;

  // Action codes of an input item
  localparam logic ActAdjust = 1'b0;
  localparam logic ActQuery  = 1'b1;

  // Datapath operation codes, one per controller step
  localparam int OpW = 4;
  localparam logic [OpW-1:0] DpNop     = 4'd0;
  localparam logic [OpW-1:0] DpCapture = 4'd1;
  localparam logic [OpW-1:0] DpOld     = 4'd2;
  localparam logic [OpW-1:0] DpUnlink  = 4'd3;
  localparam logic [OpW-1:0] DpAppend  = 4'd4;
  localparam logic [OpW-1:0] DpLink    = 4'd5;
  localparam logic [OpW-1:0] DpClose   = 4'd6;
  localparam logic [OpW-1:0] DpQscan   = 4'd7;
  localparam logic [OpW-1:0] DpQhit    = 4'd8;

  // Input item
  typedef struct packed {
    logic       action;
    logic [3:0] cpu_index;
    logic [7:0] new_load;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [3:0] chosen_cpu;
    logic       found;
    logic       moved;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic in_range;
    logic same_level;
    logic bk_empty;
    logic last_level;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/llcb_datapath.sv */
// Datapath: link, level and bucket memories with the working registers.
`default_nettype none

module llcb_datapath #(
  parameter int NUM_CPUS   = llcb_pkg::NumCpusDef,
  parameter int NUM_LEVELS = llcb_pkg::NumLevelsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  llcb_pkg::in_item_t  in_item_i,
  input  llcb_pkg::cmd_t      cmd_i,
  output llcb_pkg::sts_t      sts_o,
  output llcb_pkg::out_item_t out_item_o
);

  localparam int CW  = $clog2(NUM_CPUS);
  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int KW  = $clog2(NUM_CPUS + 1);
  localparam int CXW = (CW > 4) ? CW : 4;
  localparam int BW  = CW + KW;

  // Decode the incoming item
  logic [CXW:0]   cpu_ext;
  logic           in_range;
  logic [CW-1:0]  c_in;
  logic [8:0]     load_ext;
  logic [LW-1:0]  nl_in;

  assign cpu_ext  = (CXW+1)'(in_item_i.cpu_index);
  assign in_range = cpu_ext < (CXW+1)'(NUM_CPUS);
  assign c_in     = cpu_ext[CW-1:0];
  assign load_ext = {1'b0, in_item_i.new_load};
  assign nl_in    = (load_ext >= 9'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1) : LW'(load_ext);

  // Working registers
  logic [CW-1:0] c_q, cur_nx_q, pv_q, t_q, head_q;
  logic [LW-1:0] nl_q, cur_q, lvl_q;
  logic [3:0]    res_chosen_q;
  logic          res_found_q, res_moved_q;
  llcb_pkg::out_item_t out_q;

  // Memory ports
  logic          nx_we, pv_we, lv_we, bk_we;
  logic [CW-1:0] nx_waddr, pv_waddr, lv_waddr, nx_raddr, pv_raddr, lv_raddr;
  logic [CW-1:0] nx_wdata, pv_wdata;
  logic [LW-1:0] lv_wdata;
  logic [LW-1:0] bk_waddr, bk_raddr;
  logic [BW-1:0] bk_wdata;

  logic [CW-1:0] nx_mem [NUM_CPUS];
  logic [CW-1:0] pv_mem [NUM_CPUS];
  logic [LW-1:0] lv_mem [NUM_CPUS];
  logic [BW-1:0] bk_mem [NUM_LEVELS];

  logic [NUM_CPUS-1:0]   nx_vld_q, pv_vld_q, lv_vld_q;
  logic [NUM_LEVELS-1:0] bk_vld_q;

  logic [CW-1:0] nx_mem_rd_q, pv_mem_rd_q, nx_rst_rd_q, pv_rst_rd_q;
  logic [LW-1:0] lv_mem_rd_q;
  logic [BW-1:0] bk_mem_rd_q, bk_rst_rd_q;
  logic          nx_vld_rd_q, pv_vld_rd_q, lv_vld_rd_q, bk_vld_rd_q;

  logic [CW-1:0] nx_rd, pv_rd;
  logic [LW-1:0] lv_rd;
  logic [BW-1:0] bk_rd;
  logic [CW-1:0] bk_tail;
  logic [KW-1:0] bk_cnt;
  logic          same_level;

  // Reset contents of entries never written
  logic [CW-1:0] nx_rst_val, pv_rst_val;
  logic [BW-1:0] bk_rst_val;

  assign nx_rst_val = (nx_raddr == CW'(NUM_CPUS - 1)) ? '0 : nx_raddr + 1'b1;
  assign pv_rst_val = (pv_raddr == '0) ? CW'(NUM_CPUS - 1) : pv_raddr - 1'b1;
  assign bk_rst_val = (bk_raddr == '0) ? {CW'(0), KW'(NUM_CPUS)} : '0;

  // Read data, falling back to reset contents
  assign nx_rd   = nx_vld_rd_q ? nx_mem_rd_q : nx_rst_rd_q;
  assign pv_rd   = pv_vld_rd_q ? pv_mem_rd_q : pv_rst_rd_q;
  assign lv_rd   = lv_vld_rd_q ? lv_mem_rd_q : '0;
  assign bk_rd   = bk_vld_rd_q ? bk_mem_rd_q : bk_rst_rd_q;
  assign bk_tail = bk_rd[BW-1:KW];
  assign bk_cnt  = bk_rd[KW-1:0];

  assign same_level = (lv_rd == nl_q);

  // Steer memory ports for the current step
  always_comb begin
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    lv_we    = 1'b0;
    bk_we    = 1'b0;
    nx_waddr = c_q;
    nx_wdata = c_q;
    pv_waddr = c_q;
    pv_wdata = c_q;
    lv_waddr = c_q;
    lv_wdata = nl_q;
    bk_waddr = nl_q;
    bk_wdata = '0;
    nx_raddr = c_in;
    pv_raddr = c_in;
    lv_raddr = c_in;
    bk_raddr = '0;
    case (cmd_i.op)
      llcb_pkg::DpCapture: begin
        nx_raddr = c_in;
        bk_raddr = '0;
      end
      llcb_pkg::DpOld: begin
        lv_we    = !same_level;
        bk_raddr = lv_rd;
      end
      llcb_pkg::DpUnlink: begin
        bk_we    = 1'b1;
        bk_waddr = cur_q;
        bk_raddr = nl_q;
        if (bk_cnt <= KW'(1)) begin
          bk_wdata = '0;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = pv_q;
          nx_wdata = cur_nx_q;
          pv_we    = 1'b1;
          pv_waddr = cur_nx_q;
          pv_wdata = pv_q;
          bk_wdata = {(bk_tail == c_q) ? cur_nx_q : bk_tail, KW'(bk_cnt - 1'b1)};
        end
      end
      llcb_pkg::DpAppend: begin
        bk_we    = 1'b1;
        bk_waddr = nl_q;
        pv_we    = 1'b1;
        pv_waddr = c_q;
        nx_raddr = bk_tail;
        if (bk_cnt == '0) begin
          bk_wdata = {c_q, KW'(1)};
          nx_we    = 1'b1;
          nx_waddr = c_q;
          nx_wdata = c_q;
          pv_wdata = c_q;
        end else begin
          bk_wdata = {c_q, KW'(bk_cnt + 1'b1)};
          pv_wdata = bk_tail;
        end
      end
      llcb_pkg::DpLink: begin
        nx_we    = 1'b1;
        nx_waddr = t_q;
        nx_wdata = c_q;
        pv_we    = 1'b1;
        pv_waddr = nx_rd;
        pv_wdata = c_q;
      end
      llcb_pkg::DpClose: begin
        nx_we    = 1'b1;
        nx_waddr = c_q;
        nx_wdata = head_q;
      end
      llcb_pkg::DpQscan: begin
        bk_raddr = lvl_q + 1'b1;
        nx_raddr = bk_tail;
      end
      default: begin
        bk_raddr = '0;
      end
    endcase
  end

  // Write the memories
  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    if (lv_we) lv_mem[lv_waddr] <= lv_wdata;
    if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
  end

  // Read the memories, registered
  always_ff @(posedge clk_i) begin
    nx_mem_rd_q <= nx_mem[nx_raddr];
    pv_mem_rd_q <= pv_mem[pv_raddr];
    lv_mem_rd_q <= lv_mem[lv_raddr];
    bk_mem_rd_q <= bk_mem[bk_raddr];
    nx_rst_rd_q <= nx_rst_val;
    pv_rst_rd_q <= pv_rst_val;
    bk_rst_rd_q <= bk_rst_val;
  end

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_vld_q    <= '0;
      pv_vld_q    <= '0;
      lv_vld_q    <= '0;
      bk_vld_q    <= '0;
      nx_vld_rd_q <= 1'b0;
      pv_vld_rd_q <= 1'b0;
      lv_vld_rd_q <= 1'b0;
      bk_vld_rd_q <= 1'b0;
    end else begin
      if (nx_we) nx_vld_q[nx_waddr] <= 1'b1;
      if (pv_we) pv_vld_q[pv_waddr] <= 1'b1;
      if (lv_we) lv_vld_q[lv_waddr] <= 1'b1;
      if (bk_we) bk_vld_q[bk_waddr] <= 1'b1;
      nx_vld_rd_q <= nx_vld_q[nx_raddr];
      pv_vld_rd_q <= pv_vld_q[pv_raddr];
      lv_vld_rd_q <= lv_vld_q[lv_raddr];
      bk_vld_rd_q <= bk_vld_q[bk_raddr];
    end
  end

  // Advance the working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      llcb_pkg::DpCapture: begin
        c_q          <= c_in;
        nl_q         <= nl_in;
        lvl_q        <= '0;
        res_chosen_q <= '0;
        res_found_q  <= 1'b0;
        res_moved_q  <= 1'b0;
      end
      llcb_pkg::DpOld: begin
        cur_q    <= lv_rd;
        cur_nx_q <= nx_rd;
        pv_q     <= pv_rd;
        if (!same_level) res_moved_q <= 1'b1;
      end
      llcb_pkg::DpAppend: begin
        t_q <= bk_tail;
      end
      llcb_pkg::DpLink: begin
        head_q <= nx_rd;
      end
      llcb_pkg::DpQscan: begin
        lvl_q <= lvl_q + 1'b1;
      end
      llcb_pkg::DpQhit: begin
        res_chosen_q <= 4'(CXW'(nx_rd));
        res_found_q  <= 1'b1;
      end
      default: begin
        lvl_q <= lvl_q;
      end
    endcase
    if (cmd_i.load_out) begin
      out_q.chosen_cpu <= res_chosen_q;
      out_q.found      <= res_found_q;
      out_q.moved      <= res_moved_q;
    end
  end

  // Report status
  assign sts_o.is_query   = (in_item_i.action == llcb_pkg::ActQuery);
  assign sts_o.in_range   = in_range;
  assign sts_o.same_level = same_level;
  assign sts_o.bk_empty   = (bk_cnt == '0);
  assign sts_o.last_level = (lvl_q == LW'(NUM_LEVELS - 1));

  assign out_item_o = out_q;

endmodule

`default_nettype wire

/* hw/rtl/llcb_ctrl.sv */
// Controller: sequences adjust and query steps and owns both handshakes.
`default_nettype none

module llcb_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  llcb_pkg::sts_t  sts_i,
  output llcb_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SOld    = 4'd1;
  localparam logic [3:0] SUnlink = 4'd2;
  localparam logic [3:0] SAppend = 4'd3;
  localparam logic [3:0] SLink   = 4'd4;
  localparam logic [3:0] SClose  = 4'd5;
  localparam logic [3:0] SQscan  = 4'd6;
  localparam logic [3:0] SQhit   = 4'd7;
  localparam logic [3:0] SDone   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Pick the next step and its command
  always_comb begin
    state_d      = state_q;
    cmd_o.op     = llcb_pkg::DpNop;
    cmd_o.load_out = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = llcb_pkg::DpCapture;
          if (sts_i.is_query)      state_d = SQscan;
          else if (sts_i.in_range) state_d = SOld;
          else                     state_d = SDone;
        end
      end
      SOld: begin
        cmd_o.op = llcb_pkg::DpOld;
        state_d  = sts_i.same_level ? SDone : SUnlink;
      end
      SUnlink: begin
        cmd_o.op = llcb_pkg::DpUnlink;
        state_d  = SAppend;
      end
      SAppend: begin
        cmd_o.op = llcb_pkg::DpAppend;
        state_d  = sts_i.bk_empty ? SDone : SLink;
      end
      SLink: begin
        cmd_o.op = llcb_pkg::DpLink;
        state_d  = SClose;
      end
      SClose: begin
        cmd_o.op = llcb_pkg::DpClose;
        state_d  = SDone;
      end
      SQscan: begin
        cmd_o.op = llcb_pkg::DpQscan;
        if (!sts_i.bk_empty)      state_d = SQhit;
        else if (sts_i.last_level) state_d = SDone;
      end
      SQhit: begin
        cmd_o.op = llcb_pkg::DpQhit;
        state_d  = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Hold the result item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/least_loaded_cpu_bucket_list.sv */
// Top level of the least loaded CPU bucket list: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_item_i  (action, cpu_index, new_load)
//   out     | output    | out_valid_o/out_ready_i | out_item_o (chosen_cpu, found, moved)
//
// One item at a time; every memory has one write and one registered read port.
// Adjust: capture, then Old; on the same level it ends, else Unlink and Append,
// then Link and Close unless the bucket was empty; a CPU out of range ends at once.
// Query: the bucket scan checks one level per cycle up to the lowest occupied one.
// Reset is immediate: valid bits make unwritten entries read as their reset value.
// A result waiting at the output stalls the next finished item in its last step.
`default_nettype none

module least_loaded_cpu_bucket_list #(
  parameter int NUM_CPUS   = llcb_pkg::NumCpusDef,
  parameter int NUM_LEVELS = llcb_pkg::NumLevelsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  llcb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output llcb_pkg::out_item_t out_item_o
);

  llcb_pkg::cmd_t cmd;
  llcb_pkg::sts_t sts;

  llcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  llcb_datapath #(
    .NUM_CPUS   (NUM_CPUS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // A result is only loaded into a free or draining output slot
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a waiting item");

  // Loading a result raises the output valid
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  // Accepting an item makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is at work");

  // Ring splice only follows a tail append
  a_link_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == llcb_pkg::DpLink) |-> ($past(cmd.op) == llcb_pkg::DpAppend))
    else $error("link step out of sequence");
`endif

endmodule

`default_nettype wire
